// ===== src/argument_string_tokenizer_unit_macros.svh =====
// assertion macros shared by the tokenizer rtl
// no dependencies; included by the modules that check their own logic
`ifndef ARGUMENT_STRING_TOKENIZER_UNIT_MACROS_SVH
`define ARGUMENT_STRING_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AST_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define AST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ast_pkg.sv =====
// types, codes and constants of the argument string tokenizer
// no dependencies; used by the top level, front end, queue and back end
`timescale 1ns / 1ps

package ast_pkg;

  // input operation codes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_END  = 1'b1;

  // special bytes
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_WS_LO  = 8'h09;
  localparam logic [7:0] CH_WS_HI  = 8'h0D;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_END_ARG = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_BAD_ESC = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    QM_NONE   = 2'd0,
    QM_SINGLE = 2'd1,
    QM_DOUBLE = 2'd2
  } quote_t;

  // one result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ch;
    logic [15:0] idx;
  } res_t;

  // queue entry: one or two results caused by one input transfer
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_WS_LO) && (c <= CH_WS_HI));
  endfunction

endpackage

// ===== src/ast_in_if.sv =====
// input channel of the tokenizer: valid/ready with op and ch
// no dependencies
`timescale 1ns / 1ps

interface ast_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

// ===== src/ast_out_if.sv =====
// result channel of the tokenizer: valid/ready with kind, out_ch, arg_index
// no dependencies
`timescale 1ns / 1ps

interface ast_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_ch;
  logic [15:0] arg_index;

  modport source (output valid, output kind, output out_ch, output arg_index, input ready);
  modport sink   (input valid, input kind, input out_ch, input arg_index, output ready);
endinterface

// ===== src/argument_string_tokenizer_unit.sv =====
// channel     dir  payload                                    transfer when
// in_chan     in   op[0], ch[7:0]                             valid && ready
// out_chan    out  kind[1:0], out_ch[7:0], arg_index[15:0]    valid && ready
//
// one input byte is taken every cycle while the result side keeps up
// a transfer that causes two results holds the output register until both results are taken
// the first result of an input transfer passes through the queue and then the output register
// in ready drops only when the front-to-back queue (QueueDepth entries) is full
// reset is synchronous active low and clears state, queue and output
// top level of the tokenizer: front end, entry queue and back end
// depends on ast_pkg, ast_in_if, ast_out_if, ast_front, ast_queue, ast_back
`timescale 1ns / 1ps

module argument_string_tokenizer_unit #(
  parameter int QueueDepth = ast_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  ast_in_if.sink     in_chan,
  ast_out_if.source  out_chan
);

  logic            push;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  ast_pkg::entry_t wr_entry;
  ast_pkg::entry_t rd_entry;

  // classify bytes and build entries
  ast_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_chan(in_chan),
    .q_full (q_full),
    .push   (push),
    .entry  (wr_entry)
  );

  // decoupling queue
  ast_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .rd_entry (rd_entry)
  );

  // deliver results one per transfer
  ast_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_entry (rd_entry),
    .q_pop   (q_pop),
    .out_chan(out_chan)
  );

endmodule

// ===== src/ast_front.sv =====
// front end: takes input transfers, tracks quoting state, builds queue entries
// depends on ast_pkg, ast_in_if and the assertion macro header
`timescale 1ns / 1ps
`include "argument_string_tokenizer_unit_macros.svh"

module ast_front (
  input  logic             clk,
  input  logic             rst_n,
  ast_in_if.sink           in_chan,
  input  logic             q_full,
  output logic             push,
  output ast_pkg::entry_t  entry
);

  ast_pkg::quote_t qm_r, qm_nxt;
  logic            esc_r, esc_nxt;
  logic            open_r, open_nxt;
  logic [15:0]     count_r, count_nxt;

  logic            accept;
  logic [1:0]      n_res;
  logic            in_quote;
  logic [7:0]      qch;
  logic [15:0]     count_inc;
  logic [7:0]      c;

  assign in_chan.ready = ~q_full;
  assign accept        = in_chan.valid & in_chan.ready;
  assign c             = in_chan.ch;
  assign count_inc     = (count_r == ast_pkg::COUNT_MAX) ? count_r : count_r + 16'd1;

  // closing quote byte of the current span
  always_comb begin
    unique case (qm_r)
      ast_pkg::QM_SINGLE: begin
        in_quote = 1'b1;
        qch      = ast_pkg::CH_SQUOTE;
      end
      ast_pkg::QM_DOUBLE: begin
        in_quote = 1'b1;
        qch      = ast_pkg::CH_DQUOTE;
      end
      default: begin
        in_quote = 1'b0;
        qch      = ast_pkg::CH_NUL;
      end
    endcase
  end

  // classify the byte, form results and next state
  always_comb begin
    qm_nxt      = qm_r;
    esc_nxt     = esc_r;
    open_nxt    = open_r;
    count_nxt   = count_r;
    n_res       = 2'd0;
    entry.two   = 1'b0;
    entry.r0    = '{kind: ast_pkg::KIND_BYTE, ch: c, idx: count_r};
    entry.r1    = '{kind: ast_pkg::KIND_BYTE, ch: c, idx: count_r};
    if (accept) begin
      priority if (in_chan.op == ast_pkg::OP_END) begin
        n_res = 2'd1;
        if (esc_r) begin
          entry.r0 = '{kind: ast_pkg::KIND_BAD_ESC, ch: ast_pkg::CH_NUL, idx: count_r};
        end else if (open_r) begin
          n_res    = 2'd2;
          entry.r0 = '{kind: ast_pkg::KIND_END_ARG, ch: ast_pkg::CH_NUL, idx: count_r};
          entry.r1 = '{kind: ast_pkg::KIND_DONE, ch: ast_pkg::CH_NUL, idx: count_inc};
        end else begin
          entry.r0 = '{kind: ast_pkg::KIND_DONE, ch: ast_pkg::CH_NUL, idx: count_r};
        end
        qm_nxt    = ast_pkg::QM_NONE;
        esc_nxt   = 1'b0;
        open_nxt  = 1'b0;
        count_nxt = '0;
      end else if (c == ast_pkg::CH_NUL) begin
        // zero byte is dropped
        n_res = 2'd0;
      end else if (esc_r) begin
        esc_nxt  = 1'b0;
        open_nxt = 1'b1;
        if (in_quote && (c != qch)) begin
          n_res       = 2'd2;
          entry.r0.ch = ast_pkg::CH_BSLASH;
        end else begin
          n_res = 2'd1;
        end
      end else if (in_quote) begin
        priority if (c == qch) begin
          qm_nxt = ast_pkg::QM_NONE;
        end else if (c == ast_pkg::CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else begin
          n_res    = 2'd1;
          open_nxt = 1'b1;
        end
      end else begin
        qm_nxt = ast_pkg::QM_NONE;
        priority if (ast_pkg::is_ws(c)) begin
          if (open_r) begin
            n_res     = 2'd1;
            entry.r0  = '{kind: ast_pkg::KIND_END_ARG, ch: ast_pkg::CH_NUL, idx: count_r};
            count_nxt = count_inc;
            open_nxt  = 1'b0;
          end
        end else if (c == ast_pkg::CH_SQUOTE) begin
          qm_nxt = ast_pkg::QM_SINGLE;
        end else if (c == ast_pkg::CH_DQUOTE) begin
          qm_nxt = ast_pkg::QM_DOUBLE;
        end else if (c == ast_pkg::CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else begin
          n_res    = 2'd1;
          open_nxt = 1'b1;
        end
      end
    end
    entry.two = (n_res == 2'd2);
    push      = (n_res != 2'd0);
  end

  // tokenizer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r    <= ast_pkg::QM_NONE;
      esc_r   <= 1'b0;
      open_r  <= 1'b0;
      count_r <= '0;
    end else begin
      qm_r    <= qm_nxt;
      esc_r   <= esc_nxt;
      open_r  <= open_nxt;
      count_r <= count_nxt;
    end
  end

  // end of string leaves the state fresh
  `AST_ASSERT_NEXT(a_end_clears, clk, rst_n, accept && (in_chan.op == ast_pkg::OP_END), (count_r == '0) && !esc_r && !open_r && (qm_r == ast_pkg::QM_NONE), "state not cleared after end of string")
  // saturated count stays put until the string ends
  `AST_ASSERT_NEXT(a_count_sat, clk, rst_n, (count_r == ast_pkg::COUNT_MAX) && !(accept && (in_chan.op == ast_pkg::OP_END)), count_r == ast_pkg::COUNT_MAX, "argument count left saturation")
  // a push never lands on a full queue
  `AST_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !q_full, "push while queue full")

endmodule

// ===== src/ast_queue.sv =====
// short flip-flop queue of result entries between front and back
// depends on ast_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "argument_string_tokenizer_unit_macros.svh"

module ast_queue #(
  parameter int Depth = ast_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ast_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output ast_pkg::entry_t rd_entry
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ast_pkg::entry_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full      = (count_r == FullCnt);
  assign not_empty = (count_r != '0);
  assign rd_entry  = mem_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  `AST_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, not_empty, "pop from empty queue")
  `AST_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= FullCnt, "queue occupancy beyond depth")

endmodule

// ===== src/ast_back.sv =====
// back end: unpacks queue entries into single results behind an output register
// depends on ast_pkg, ast_out_if and the assertion macro header
`timescale 1ns / 1ps
`include "argument_string_tokenizer_unit_macros.svh"

module ast_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  ast_pkg::entry_t q_entry,
  output logic            q_pop,
  ast_out_if.source       out_chan
);

  logic          out_valid_r, out_valid_nxt;
  ast_pkg::res_t out_r, out_nxt;
  logic          sec_valid_r, sec_valid_nxt;
  ast_pkg::res_t sec_r, sec_nxt;
  logic          slot_free;

  assign slot_free = ~out_valid_r | out_chan.ready;
  assign q_pop     = q_valid & slot_free & ~sec_valid_r;

  // load the output register from the second result or from the queue
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    sec_valid_nxt = sec_valid_r;
    sec_nxt       = sec_r;
    if (slot_free) begin
      priority if (sec_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = sec_r;
        sec_valid_nxt = 1'b0;
      end else if (q_valid) begin
        out_valid_nxt = 1'b1;
        out_nxt       = q_entry.r0;
        sec_valid_nxt = q_entry.two;
        sec_nxt       = q_entry.r1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    sec_r <= sec_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.kind      = out_r.kind;
  assign out_chan.out_ch    = out_r.ch;
  assign out_chan.arg_index = out_r.idx;

  // a pending second result always sits behind a shown first one
  `AST_ASSERT_IMPL(a_sec_behind_out, clk, rst_n, sec_valid_r, out_valid_r, "second result without first")
  // the second result goes out right after the first one is taken
  `AST_ASSERT_NEXT(a_sec_follows, clk, rst_n, sec_valid_r && out_chan.ready, out_valid_r && !sec_valid_r, "second result not forwarded")

endmodule
